### sv/ttir_pkg.sv
package ttir_pkg;

	// widths fixed by the item fields
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned CONSUMED_W = 16;
	localparam int unsigned RADIX_W    = 6;
	localparam int unsigned DIGIT_W    = 7;
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 88;

	localparam int unsigned MAX_CHARS_DEF = 65535;

	// register indexes on the configuration channel
	localparam logic REG_RADIX  = 1'b0;
	localparam logic REG_SIGNED = 1'b1;

	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [DIGIT_W-1:0] DIGIT_NONE  = DIGIT_W'(99);

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_DIGIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

	// outcome of one digit step
	typedef struct packed {
		logic               ok;
		logic               ovf;
		logic [VALUE_W-1:0] acc;
	} mac_res_t;

	// finished result handed to the output register
	typedef struct packed {
		logic [CONSUMED_W-1:0] consumed;
		logic [STATUS_W-1:0]   status;
		logic [VALUE_W-1:0]    value;
	} result_t;

	// character to digit value, DIGIT_NONE for anything else
	function automatic logic [DIGIT_W-1:0] digit_value(input logic [BYTE_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		d = DIGIT_NONE;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = DIGIT_W'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h5a) begin
			d = DIGIT_W'(c - 8'h41 + 8'd10);
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			d = DIGIT_W'(c - 8'h61 + 8'd10);
		end
		return d;
	endfunction

endpackage

### sv/text_to_integer_radix_parser.sv
// Streaming text-to-integer parser.
// Bytes of a text buffer enter on the s_ channel, one item per byte, the
// final byte of each buffer flagged by s_tlast; an empty buffer is a single
// NUL byte with s_tlast set. Leading blanks and one sign are skipped, an
// optional 0x / 0b prefix is honoured, and digits accumulate into 64 bits
// with saturation. Each buffer yields exactly one item on the m_ channel
// carrying value, status and bytes consumed; no item comes out for the other
// bytes. Base and signed limits are set through the cfg_ channel, which is
// always ready and should be written only between buffers.
// Each byte is registered in the input register on entry; a last byte then
// loads the output register, which raises m_tvalid, and waits in the input
// register while the output register is still full.
// Throughput: one byte per cycle, set by the combinational 64x6 multiply-add
// of the digit step. A byte keeps flowing while a result waits; only a last
// byte stalls when the output register is still full and m_tready is low.
// Reset clears the parse state, empties the input and output registers, and
// sets radix to 10 and signed mode on.
module text_to_integer_radix_parser #(
	parameter int unsigned MAX_CHARS = ttir_pkg::MAX_CHARS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ttir_pkg::IN_DATA_W-1:0]      s_tdata,  // [7:0] text_byte
	input  logic                                s_tlast,  // is_last
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [63:0] value, [65:64] status, [81:66] consumed, [87:82] zero
	output logic [ttir_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [ttir_pkg::RADIX_W-1:0]        cfg_data
);

	logic                          in_vld_s1;
	logic [ttir_pkg::BYTE_W-1:0]   byte_s1;
	logic                          last_s1;
	logic                          advance;
	logic                          out_free;
	logic [ttir_pkg::RADIX_W-1:0]  radix_q;
	logic                          signed_q;
	ttir_pkg::result_t             result;
	ttir_pkg::result_t             out_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= ttir_pkg::RADIX_RESET;
			signed_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ttir_pkg::REG_RADIX:  radix_q  <= cfg_data;
				ttir_pkg::REG_SIGNED: signed_q <= cfg_data[0];
				default:              radix_q  <= radix_q;
			endcase
		end
	end

	// input register: a last byte waits for room in the output register
	assign out_free = !m_tvalid || m_tready;
	assign advance  = in_vld_s1 && (!last_s1 || out_free);
	assign s_tready = !in_vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			in_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata[ttir_pkg::BYTE_W-1:0];
			last_s1 <= s_tlast;
		end
	end

	ttir_core #(
		.MAX_CHARS (MAX_CHARS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.text_byte   (byte_s1),
		.is_last     (last_s1),
		.radix       (radix_q),
		.signed_mode (signed_q),
		.result      (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance && last_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q <= result;
		end
	end

	assign m_tdata = ttir_pkg::OUT_DATA_W'(out_q);

endmodule

### sv/ttir_mac.sv
module ttir_mac (
	input  logic [ttir_pkg::VALUE_W-1:0] acc,
	input  logic                         ovf,
	input  logic [ttir_pkg::RADIX_W-1:0] base,
	input  logic [ttir_pkg::DIGIT_W-1:0] digit,
	input  logic                         signed_mode,
	input  logic                         negative,
	output ttir_pkg::mac_res_t           res
);

	localparam int unsigned PW = ttir_pkg::VALUE_W + ttir_pkg::RADIX_W + 1;

	logic [PW-1:0]                prod;
	logic [ttir_pkg::VALUE_W-1:0] limit;
	logic                         too_big;

	// limit of the current mode and sign
	always_comb begin
		if (signed_mode) begin
			limit = negative ? {1'b1, {(ttir_pkg::VALUE_W-1){1'b0}}}
			                 : {1'b0, {(ttir_pkg::VALUE_W-1){1'b1}}};
		end else begin
			limit = '1;
		end
	end

	// multiply-add by the base and range check
	assign prod    = PW'(acc) * PW'(base) + PW'(digit);
	assign too_big = prod > PW'(limit);

	always_comb begin
		res.ok  = (base >= ttir_pkg::RADIX_W'(2)) && (ttir_pkg::RADIX_W'(digit) < base)
		          && (digit < ttir_pkg::DIGIT_W'(ttir_pkg::RADIX_MAX));
		res.ovf = ovf || too_big;
		res.acc = res.ovf ? acc : prod[ttir_pkg::VALUE_W-1:0];
	end

endmodule

### sv/ttir_core.sv
module ttir_core #(
	parameter int unsigned MAX_CHARS = ttir_pkg::MAX_CHARS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [ttir_pkg::BYTE_W-1:0]  text_byte,
	input  logic                         is_last,
	input  logic [ttir_pkg::RADIX_W-1:0] radix,
	input  logic                         signed_mode,
	output ttir_pkg::result_t            result
);

	localparam int unsigned POS_W = $clog2(64'(MAX_CHARS) + 64'd1);

	typedef enum logic [5:0] {
		PH_BLANK  = 6'b000001,
		PH_SIGNED = 6'b000010,
		PH_ZERO   = 6'b000100,
		PH_PREFIX = 6'b001000,
		PH_DIGITS = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	phase_t                         phase_q, phase_n;
	logic                           neg_q, neg_n;
	logic [ttir_pkg::RADIX_W-1:0]   base_q, base_n;
	logic [ttir_pkg::VALUE_W-1:0]   acc_q, acc_n;
	logic                           ovf_q, ovf_n;
	logic                           seen_q, seen_n;
	logic [ttir_pkg::BYTE_W-1:0]    held_q, held_n;
	logic [POS_W-1:0]               pos_q;
	logic [POS_W-1:0]               end_q, end_n;

	logic                           in_range;
	logic [POS_W-1:0]               pos_inc;
	logic [ttir_pkg::DIGIT_W-1:0]   digit;
	logic                           do_digit;
	logic [ttir_pkg::RADIX_W-1:0]   dig_base;
	logic [ttir_pkg::RADIX_W-1:0]   first_base;
	logic                           c_zero, c_blank, c_hex, c_x, c_b, c_bin;
	logic                           r_pref;
	ttir_pkg::mac_res_t             mac;

	assign in_range = 64'(pos_q) < 64'(MAX_CHARS);
	assign pos_inc  = POS_W'(pos_q + 1'b1);
	assign digit    = ttir_pkg::digit_value(text_byte);

	// character classes
	assign c_zero  = text_byte == 8'h30;
	assign c_blank = text_byte == 8'h20 || text_byte == 8'h09 || text_byte == 8'h0a
	                 || text_byte == 8'h0d;
	assign c_hex   = (text_byte >= 8'h30 && text_byte <= 8'h39)
	                 || (text_byte >= 8'h41 && text_byte <= 8'h46)
	                 || (text_byte >= 8'h61 && text_byte <= 8'h66);
	assign c_bin   = text_byte == 8'h30 || text_byte == 8'h31;
	assign c_x     = text_byte == 8'h78 || text_byte == 8'h58;
	assign c_b     = text_byte == 8'h62 || text_byte == 8'h42;
	assign r_pref  = radix == '0 || radix == ttir_pkg::RADIX_W'(16)
	                 || radix == ttir_pkg::RADIX_W'(2);
	assign first_base = (radix == '0) ? (c_zero ? ttir_pkg::RADIX_W'(8)
	                                            : ttir_pkg::RADIX_W'(10)) : radix;

	ttir_mac u_mac (
		.acc         (acc_q),
		.ovf         (ovf_q),
		.base        (dig_base),
		.digit       (digit),
		.signed_mode (signed_mode),
		.negative    (neg_q),
		.res         (mac)
	);

	// phase sequencing for one byte
	always_comb begin
		phase_n  = phase_q;
		neg_n    = neg_q;
		base_n   = base_q;
		acc_n    = acc_q;
		ovf_n    = ovf_q;
		seen_n   = seen_q;
		held_n   = held_q;
		end_n    = end_q;
		do_digit = 1'b0;
		dig_base = base_q;

		if (in_range) begin
			unique case (phase_q)
				PH_BLANK, PH_SIGNED: begin
					if (phase_q == PH_BLANK && c_blank) begin
						phase_n = PH_BLANK;
					end else if (phase_q == PH_BLANK && text_byte == 8'h2d) begin
						neg_n   = 1'b1;
						phase_n = PH_SIGNED;
					end else if (phase_q == PH_BLANK && text_byte == 8'h2b) begin
						phase_n = PH_SIGNED;
					end else if (c_zero && r_pref) begin
						base_n  = radix;
						phase_n = PH_ZERO;
						seen_n  = 1'b1;
						acc_n   = '0;
						end_n   = pos_inc;
					end else if (first_base < ttir_pkg::RADIX_W'(2)
					             || first_base > ttir_pkg::RADIX_MAX) begin
						base_n  = radix;
						phase_n = PH_DONE;
					end else begin
						dig_base = first_base;
						do_digit = 1'b1;
					end
				end
				PH_ZERO: begin
					if (c_x && (base_q == '0 || base_q == ttir_pkg::RADIX_W'(16))) begin
						held_n  = text_byte;
						phase_n = PH_PREFIX;
					end else if (c_b && (base_q == '0 || base_q == ttir_pkg::RADIX_W'(2))) begin
						held_n  = text_byte;
						phase_n = PH_PREFIX;
					end else begin
						dig_base = (base_q == '0) ? ttir_pkg::RADIX_W'(8) : base_q;
						do_digit = 1'b1;
					end
				end
				PH_PREFIX: begin
					if ((held_q == 8'h78 || held_q == 8'h58) && c_hex) begin
						dig_base = ttir_pkg::RADIX_W'(16);
						do_digit = 1'b1;
					end else if ((held_q == 8'h62 || held_q == 8'h42) && c_bin) begin
						dig_base = ttir_pkg::RADIX_W'(2);
						do_digit = 1'b1;
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_DIGITS: begin
					do_digit = 1'b1;
				end
				PH_DONE: begin
					phase_n = PH_DONE;
				end
				default: begin
					phase_n = PH_DONE;
				end
			endcase

			// digit accumulation
			if (do_digit) begin
				base_n = dig_base;
				if (mac.ok) begin
					phase_n = PH_DIGITS;
					acc_n   = mac.acc;
					ovf_n   = mac.ovf;
					seen_n  = 1'b1;
					end_n   = pos_inc;
				end else begin
					phase_n = PH_DONE;
				end
			end
		end
	end

	// result from the state after this byte
	always_comb begin
		if (!seen_n) begin
			result.value    = '0;
			result.status   = ttir_pkg::ST_NO_DIGIT;
			result.consumed = '0;
		end else if (ovf_n) begin
			if (signed_mode) begin
				result.value = neg_n ? {1'b1, {(ttir_pkg::VALUE_W-1){1'b0}}}
				                     : {1'b0, {(ttir_pkg::VALUE_W-1){1'b1}}};
			end else begin
				result.value = '1;
			end
			result.status   = ttir_pkg::ST_RANGE;
			result.consumed = ttir_pkg::CONSUMED_W'(end_n);
		end else begin
			result.value    = neg_n ? (ttir_pkg::VALUE_W'(0) - acc_n) : acc_n;
			result.status   = ttir_pkg::ST_OK;
			result.consumed = ttir_pkg::CONSUMED_W'(end_n);
		end
	end

	// parse state, cleared after each buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLANK;
			neg_q   <= 1'b0;
			base_q  <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			seen_q  <= 1'b0;
			held_q  <= '0;
			pos_q   <= '0;
			end_q   <= '0;
		end else if (step) begin
			if (is_last) begin
				phase_q <= PH_BLANK;
				neg_q   <= 1'b0;
				base_q  <= '0;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				seen_q  <= 1'b0;
				held_q  <= '0;
				pos_q   <= '0;
				end_q   <= '0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				base_q  <= base_n;
				acc_q   <= acc_n;
				ovf_q   <= ovf_n;
				seen_q  <= seen_n;
				held_q  <= held_n;
				end_q   <= end_n;
				if (in_range) begin
					pos_q <= pos_inc;
				end
			end
		end
	end

endmodule

### tb/text_to_integer_radix_parser_tb.sv
module text_to_integer_radix_parser_tb;

	localparam int unsigned CHAR_LIMIT  = ttir_pkg::MAX_CHARS_DEF;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_BYTES = 85;

	// blank characters
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_SP  = 8'h20;

	typedef enum logic [5:0] {
		SCAN_BLANK  = 6'b000001,
		SCAN_SIGN   = 6'b000010,
		SCAN_ZERO   = 6'b000100,
		SCAN_PREFIX = 6'b001000,
		SCAN_DIGITS = 6'b010000,
		SCAN_DONE   = 6'b100000
	} scan_t;

	typedef struct packed {
		logic [7:0] text;
		logic       last;
	} text_item_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [ttir_pkg::IN_DATA_W-1:0]  s_tdata   = '0;  // [7:0] text_byte
	logic                            s_tlast   = 1'b0; // is_last
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	// [63:0] value, [65:64] status, [81:66] consumed, [87:82] zero
	logic [ttir_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic                            cfg_index = ttir_pkg::REG_RADIX;
	logic [ttir_pkg::RADIX_W-1:0]    cfg_data  = '0;

	// register copies as written to the block
	logic [ttir_pkg::RADIX_W-1:0] radix_reg  = ttir_pkg::RADIX_RESET;
	logic                         signed_reg = 1'b1;

	// parser state of the predictor
	scan_t        scan_state;
	logic         minus_seen;
	logic [5:0]   work_base;
	logic [63:0]  accum;
	logic         saturated;
	logic         got_digit;
	logic [7:0]   held_char;
	int unsigned  byte_pos;
	int unsigned  digits_end;

	text_item_t         pending_bytes[$];
	logic [7:0]         staged_chars[$];
	ttir_pkg::result_t  awaited_results[$];
	int unsigned fail_count     = 0;
	int unsigned cycle_count    = 0;
	int unsigned hold_left      = 0;
	bit          hold_used      = 1'b0;
	bit          pressure_phase = 1'b0;
	bit          steady         = 1'b0;
	logic        hold_off;

	logic [7:0] blank_chars[4] = '{CH_SP, CH_TAB, CH_CR, CH_LF};

	text_to_integer_radix_parser DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// character value in bases up to 36, 99 for anything else
	function automatic int unsigned char_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "Z") return c - "A" + 10;
		if (c >= "a" && c <= "z") return c - "a" + 10;
		return 99;
	endfunction

	// magnitude limit for the current sign and mode, also the saturated value
	function automatic logic [63:0] range_limit();
		if (!signed_reg) return '1;
		return minus_seen ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
	endfunction

	task automatic clear_scan();
		scan_state = SCAN_BLANK;
		minus_seen = 1'b0;
		work_base  = '0;
		accum      = '0;
		saturated  = 1'b0;
		got_digit  = 1'b0;
		held_char  = '0;
		byte_pos   = 0;
		digits_end = 0;
	endtask

	// one digit in the digit phase, saturating multiply-add
	task automatic add_digit(input logic [7:0] c, input int unsigned pos);
		int unsigned d;
		logic [63:0] lim, cut, cut_rem;
		d = char_digit(c);
		if (work_base < 2 || d >= work_base) begin
			scan_state = SCAN_DONE;
			return;
		end
		lim = range_limit();
		cut = lim / work_base;
		cut_rem = lim % work_base;
		if (saturated || accum > cut || (accum == cut && d > cut_rem)) begin
			saturated = 1'b1;
		end else begin
			accum = accum * work_base + d;
		end
		got_digit = 1'b1;
		digits_end = pos + 1;
	endtask

	// first character after blanks and sign fixes the base
	task automatic start_number(input logic [7:0] c, input int unsigned pos);
		logic [5:0] b;
		work_base = radix_reg;
		if (c == "0" && (radix_reg == 0 || radix_reg == 16 || radix_reg == 2)) begin
			scan_state = SCAN_ZERO;
			got_digit = 1'b1;
			accum = '0;
			digits_end = pos + 1;
			return;
		end
		b = (radix_reg == 0) ? ((c == "0") ? 6'd8 : 6'd10) : radix_reg;
		if (b < 2 || b > ttir_pkg::RADIX_MAX) begin
			scan_state = SCAN_DONE;
			return;
		end
		work_base = b;
		scan_state = SCAN_DIGITS;
		add_digit(c, pos);
	endtask

	// advance the predictor by one accepted item
	task automatic scan_byte(input logic [7:0] c, input logic last);
		ttir_pkg::result_t r;
		if (byte_pos < CHAR_LIMIT) begin
			case (scan_state)
				SCAN_BLANK: begin
					if (c == "-") begin
						minus_seen = 1'b1;
						scan_state = SCAN_SIGN;
					end else if (c == "+") begin
						scan_state = SCAN_SIGN;
					end else if (!(c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR)) begin
						start_number(c, byte_pos);
					end
				end
				SCAN_SIGN: start_number(c, byte_pos);
				SCAN_ZERO: begin
					if ((c == "x" || c == "X") && (work_base == 0 || work_base == 16)) begin
						held_char = c;
						scan_state = SCAN_PREFIX;
					end else if ((c == "b" || c == "B") && (work_base == 0 || work_base == 2)) begin
						held_char = c;
						scan_state = SCAN_PREFIX;
					end else begin
						if (work_base == 0) work_base = 6'd8;
						scan_state = SCAN_DIGITS;
						add_digit(c, byte_pos);
					end
				end
				SCAN_PREFIX: begin
					if ((held_char == "x" || held_char == "X") && char_digit(c) < 16) begin
						work_base = 6'd16;
						scan_state = SCAN_DIGITS;
						add_digit(c, byte_pos);
					end else if ((held_char == "b" || held_char == "B") &&
						(c == "0" || c == "1")) begin
						work_base = 6'd2;
						scan_state = SCAN_DIGITS;
						add_digit(c, byte_pos);
					end else begin
						scan_state = SCAN_DONE;
					end
				end
				SCAN_DIGITS: add_digit(c, byte_pos);
				default: ;
			endcase
			byte_pos++;
		end
		if (last) begin
			if (!got_digit) begin
				r.value = '0;
				r.status = ttir_pkg::ST_NO_DIGIT;
				r.consumed = '0;
			end else if (saturated) begin
				r.value = range_limit();
				r.status = ttir_pkg::ST_RANGE;
				r.consumed = ttir_pkg::CONSUMED_W'(digits_end);
			end else begin
				r.value = minus_seen ? -accum : accum;
				r.status = ttir_pkg::ST_OK;
				r.consumed = ttir_pkg::CONSUMED_W'(digits_end);
			end
			awaited_results.push_back(r);
			clear_scan();
		end
	endtask

	// staged characters become one buffer, an empty one a single nul
	task automatic flush_staged();
		text_item_t it;
		if (staged_chars.size() == 0) staged_chars.push_back(8'h00);
		while (staged_chars.size() != 0) begin
			it.text = staged_chars.pop_front();
			it.last = (staged_chars.size() == 0);
			pending_bytes.push_back(it);
		end
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) staged_chars.push_back(s[i]);
		flush_staged();
	endtask

	// random buffer, mostly well formed numbers for the current base
	task automatic add_random_buffer(input bit brief);
		int unsigned n, p, b, v;
		if ($urandom_range(99) < 15) begin
			n = $urandom_range(brief ? 2 : 6, 1);
			repeat (n) staged_chars.push_back(8'($urandom_range(255)));
		end else begin
			if (!brief) begin
				repeat ($urandom_range(3)) staged_chars.push_back(blank_chars[$urandom_range(3)]);
			end
			case ($urandom_range(2))
				1: staged_chars.push_back("-");
				2: staged_chars.push_back("+");
				default: ;
			endcase
			b = (radix_reg >= 2 && radix_reg <= ttir_pkg::RADIX_MAX) ? radix_reg : 10;
			p = (!brief && $urandom_range(99) < 30) ? $urandom_range(3, 1) : 0;
			if (p != 0) staged_chars.push_back("0");
			if (p == 1) begin
				staged_chars.push_back($urandom_range(1) ? "x" : "X");
				if (radix_reg == 0) b = 16;
			end else if (p == 2) begin
				staged_chars.push_back($urandom_range(1) ? "b" : "B");
				if (radix_reg == 0) b = 2;
			end else if (p == 3 && radix_reg == 0) begin
				b = 8;
			end
			if (brief) n = $urandom_range(2, 1);
			else if ($urandom_range(99) < 20) n = $urandom_range(25, 15);
			else n = $urandom_range(8, 1);
			repeat (n) begin
				v = ($urandom_range(99) < 5) ? $urandom_range(35) : $urandom_range(b - 1);
				if (v < 10) staged_chars.push_back(8'("0" + v));
				else staged_chars.push_back(8'(($urandom_range(1) ? "a" : "A") + v - 10));
			end
			if (!brief && $urandom_range(99) < 20) begin
				repeat ($urandom_range(3, 1)) staged_chars.push_back(8'($urandom_range(255)));
			end
		end
		flush_staged();
	endtask

	// configuration write, only called while the block is idle
	task automatic write_reg(input logic idx, input logic [ttir_pkg::RADIX_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == ttir_pkg::REG_RADIX) radix_reg = data;
		else signed_reg = data[0];
		@(negedge clk);
	endtask

	task automatic set_mode(input logic [ttir_pkg::RADIX_W-1:0] base, input logic sgn);
		write_reg(ttir_pkg::REG_RADIX, base);
		write_reg(ttir_pkg::REG_SIGNED, {{(ttir_pkg::RADIX_W-1){1'b0}}, sgn});
	endtask

	// wait until every item is taken and every result checked
	task automatic wait_drained();
		@(negedge clk);
		while (pending_bytes.size() != 0 || s_tvalid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// sender: offers queued items, predicts on every accepted one
	always @(posedge clk) begin
		text_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
					it = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= it.text;
					s_tlast  <= it.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, started once in the pressure phase
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (pressure_phase && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	assign hold_off = (hold_left != 0);

	// receiver: checks each result against the oldest prediction
	always @(posedge clk) begin
		ttir_pkg::result_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = ttir_pkg::result_t'(m_tdata[$bits(ttir_pkg::result_t)-1:0]);
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h", $time, got);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (got.value !== want.value) begin
						$display("%0t: value expected %h actual %h", $time, want.value, got.value);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status,
							got.status);
						fail_count++;
					end
					if (got.consumed !== want.consumed) begin
						$display("%0t: consumed expected %0d actual %0d", $time, want.consumed,
							got.consumed);
						fail_count++;
					end
				end
			end
			m_tready <= !hold_off && (steady || $urandom_range(99) >= 6);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** text_to_integer_radix_parser: FAILED **");
			$finish;
		end
	end

	initial begin
		clear_scan();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: decimal, signed
		send_text("");
		staged_chars = '{CH_SP, CH_TAB, CH_CR, CH_LF};
		send_text("-42");
		send_text("+17 x");
		send_text("9223372036854775807");
		send_text("-9223372036854775808");
		send_text("9223372036854775808");
		send_text("-99999999999999999999");
		send_text("abc");
		send_text("-");
		staged_chars.push_back(8'hff);
		send_text("7");
		wait_drained();

		// auto base with prefixes and octal
		set_mode(6'd0, 1'b1);
		send_text("0x1F");
		send_text("0X");
		send_text("0xg");
		send_text("0b101");
		send_text("0B2");
		send_text("017");
		send_text("08");
		send_text("-0");
		wait_drained();

		// hex unsigned, negation and saturation
		set_mode(6'd16, 1'b0);
		send_text("ffffffffffffffff");
		send_text("-1");
		send_text("1ffffffffffffffff0");
		send_text("-0x10");
		send_text("0b1");
		wait_drained();

		set_mode(ttir_pkg::RADIX_MAX, 1'b0);
		send_text("zZ");
		send_text("-zzzzzzzzzzzzzz");
		wait_drained();

		set_mode(6'd2, 1'b1);
		send_text("0b1101");
		send_text("-0b");
		wait_drained();

		// bases out of range
		set_mode(6'd1, 1'b1);
		send_text("123");
		wait_drained();
		set_mode(6'd63, 1'b0);
		send_text("5");
		wait_drained();
		set_mode(6'd37, 1'b1);
		send_text("1");
		wait_drained();

		// random phases, one without idling and one under receiver hold-off
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(6))
				0: set_mode(6'd0, 1'($urandom_range(1)));
				1: set_mode(6'd2, 1'($urandom_range(1)));
				2: set_mode(6'd8, 1'($urandom_range(1)));
				3: set_mode(6'd10, 1'($urandom_range(1)));
				4: set_mode(6'd16, 1'($urandom_range(1)));
				5: set_mode(ttir_pkg::RADIX_MAX, 1'($urandom_range(1)));
				default: set_mode(ttir_pkg::RADIX_W'($urandom_range(63)), 1'($urandom_range(1)));
			endcase
			steady = (ph == 2);
			pressure_phase = (ph == 5);
			while (pending_bytes.size() < PHASE_BYTES) add_random_buffer(ph == 5);
			wait_drained();
			steady = 1'b0;
			pressure_phase = 1'b0;
		end

		if (fail_count == 0) begin
			$display("** text_to_integer_radix_parser: PASSED **");
		end else begin
			$display("** text_to_integer_radix_parser: FAILED **");
		end
		$finish;
	end

endmodule

### files.f
sv/ttir_pkg.sv
sv/ttir_mac.sv
sv/ttir_core.sv
sv/text_to_integer_radix_parser.sv
tb/text_to_integer_radix_parser_tb.sv
